// ----- sv/ihc_pkg.sv -----
// shared types, constants and helpers for the ipv4 header check block
// no dependencies
package ihc_pkg;

    localparam int MAX_HDR_BYTES_DEF = 60;
    localparam int CNT_W = 6;

    localparam logic [CNT_W-1:0] MIN_HDR_BYTES = 6'd20;
    localparam logic [CNT_W-1:0] TTL_POS       = 6'd8;
    localparam logic [CNT_W-1:0] PROTO_POS     = 6'd9;
    localparam logic [CNT_W-1:0] CK_HI_POS     = 6'd10;
    localparam logic [CNT_W-1:0] CK_LO_POS     = 6'd11;

    localparam logic [1:0] ST_FWD     = 2'd0;
    localparam logic [1:0] ST_BAD_SUM = 2'd1;
    localparam logic [1:0] ST_BAD_LEN = 2'd2;

    localparam logic [1:0] SRC_LEN  = 2'd0;
    localparam logic [1:0] SRC_SUM  = 2'd1;
    localparam logic [1:0] SRC_BYTE = 2'd2;

    typedef struct packed {
        logic       start_hdr;
        logic       store;
        logic       latch_hc;
        logic       rd_issue;
        logic       rd_next;
        logic       out_load;
        logic [1:0] out_src;
    } t_dp_cmd;

    typedef struct packed {
        logic start;
        logic len_bad;
        logic last_byte;
        logic sum_ok;
        logic rd_last;
        logic out_free;
    } t_dp_sts;

    // one's complement add with end-around carry
    function automatic logic [15:0] fold_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

// ----- sv/ihc_in_if.sv -----
// header byte channel: valid/ready handshake with byte and start flag
// no dependencies
interface ihc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] header_byte;
    logic       start_flag;

    modport source (output valid, output header_byte, output start_flag, input ready);
    modport sink   (input valid, input header_byte, input start_flag, output ready);
endinterface

// ----- sv/ihc_out_if.sv -----
// result channel: valid/ready handshake with rewritten byte and status
// no dependencies
interface ihc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       has_byte;
    logic [1:0] check_status;
    logic       end_of_run;

    modport source (output valid, output out_byte, output has_byte,
                    output check_status, output end_of_run, input ready);
    modport sink   (input valid, input out_byte, input has_byte,
                    input check_status, input end_of_run, output ready);
endinterface

// ----- sv/ipv4_header_check_and_ttl_update.sv -----
// top level: ipv4 header checksum check and ttl decrement with incremental update
// depends on ihc_pkg, ihc_in_if, ihc_out_if, ihc_ctrl, ihc_datapath
//
//  port    dir   payload                                          handshake
//  i_hdr   in    header_byte[7:0], start_flag                     valid/ready
//  o_res   out   out_byte[7:0], has_byte, check_status[1:0],      valid/ready
//                end_of_run
//
// header bytes are taken one per handshake; after the last byte a check state tests the sum
// a good header replays byte by byte: a store read, then a load of the output register
// input is held off during check and replay, and while an unread result blocks the register
// reset is synchronous, active low, and leaves the block idle with no result pending
// a stalled output holds its result; the sequencer waits on it without losing state
module ipv4_header_check_and_ttl_update #(
    parameter int MAX_HEADER_BYTES = ihc_pkg::MAX_HDR_BYTES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ihc_in_if.sink    i_hdr,
    ihc_out_if.source o_res
);

    ihc_pkg::t_dp_cmd cmd;
    ihc_pkg::t_dp_sts sts;
    logic             in_ready;

    assign i_hdr.ready = in_ready;

    ihc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_hdr.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ihc_datapath #(
        .MAX_HEADER_BYTES (MAX_HEADER_BYTES)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .i_hdr   (i_hdr),
        .o_res   (o_res)
    );

endmodule

// ----- sv/ihc_datapath.sv -----
// datapath: header store, checksum accumulation, incremental update, output register
// depends on ihc_pkg, ihc_in_if, ihc_out_if
module ihc_datapath #(
    parameter int MAX_HEADER_BYTES = ihc_pkg::MAX_HDR_BYTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ihc_pkg::t_dp_cmd     i_cmd,
    output ihc_pkg::t_dp_sts     o_sts,
    ihc_in_if.sink               i_hdr,
    ihc_out_if.source            o_res
);

    localparam int AW = $clog2(MAX_HEADER_BYTES);
    localparam logic [ihc_pkg::CNT_W-1:0] MAX_LEN = ihc_pkg::CNT_W'(MAX_HEADER_BYTES);

    logic [7:0]                 r_mem [MAX_HEADER_BYTES];
    logic [ihc_pkg::CNT_W-1:0]  r_count;
    logic [ihc_pkg::CNT_W-1:0]  r_len;
    logic [15:0]                r_sum;
    logic [15:0]                r_rc;
    logic [7:0]                 r_hold;
    logic [7:0]                 r_ttl;
    logic [7:0]                 r_proto;
    logic [15:0]                r_hc;
    logic [ihc_pkg::CNT_W-1:0]  r_rd_idx;
    logic [7:0]                 r_rd_data;
    logic                       r_o_valid;
    logic [7:0]                 r_o_byte;
    logic                       r_o_has;
    logic [1:0]                 r_o_status;
    logic                       r_o_end;

    logic [ihc_pkg::CNT_W-1:0]  n_len;
    logic [15:0]                n_word;
    logic [7:0]                 n_ttl;
    logic [15:0]                n_hc;
    logic [7:0]                 n_byte;
    logic                       rd_last;

    assign n_len   = {i_hdr.header_byte[3:0], 2'b00};
    assign n_word  = (r_count == ihc_pkg::CK_LO_POS) ? 16'd0 : {r_hold, i_hdr.header_byte};
    assign n_ttl   = r_ttl - 8'd1;
    assign n_hc    = ~ihc_pkg::fold_add(ihc_pkg::fold_add(~r_rc, ~{r_ttl, r_proto}),
                                        {n_ttl, r_proto});
    assign rd_last = (r_rd_idx + 6'd1) == r_len;

    always_comb begin
        case (r_rd_idx)
            ihc_pkg::TTL_POS:   n_byte = n_ttl;
            ihc_pkg::CK_HI_POS: n_byte = r_hc[15:8];
            ihc_pkg::CK_LO_POS: n_byte = r_hc[7:0];
            default:            n_byte = r_rd_data;
        endcase
    end

    assign o_sts.start     = i_hdr.start_flag;
    assign o_sts.len_bad   = (n_len < ihc_pkg::MIN_HDR_BYTES) || (n_len > MAX_LEN);
    assign o_sts.last_byte = (r_count + 6'd1) == r_len;
    assign o_sts.sum_ok    = (~r_sum) == r_rc;
    assign o_sts.rd_last   = rd_last;
    assign o_sts.out_free  = !r_o_valid || o_res.ready;

    // header store
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_hdr) begin
            r_mem[0] <= i_hdr.header_byte;
        end else if (i_cmd.store) begin
            r_mem[r_count[AW-1:0]] <= i_hdr.header_byte;
        end
        if (i_cmd.rd_issue) begin
            r_rd_data <= r_mem[r_rd_idx[AW-1:0]];
        end
    end

    // collection and checksum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_len   <= '0;
            r_sum   <= '0;
            r_rc    <= '0;
            r_hold  <= '0;
        end else if (i_cmd.start_hdr) begin
            r_count <= 6'd1;
            r_len   <= n_len;
            r_sum   <= '0;
            r_rc    <= '0;
            r_hold  <= i_hdr.header_byte;
        end else if (i_cmd.store) begin
            r_count <= r_count + 6'd1;
            if (!r_count[0]) begin
                r_hold <= i_hdr.header_byte;
            end else begin
                r_sum <= ihc_pkg::fold_add(r_sum, n_word);
                if (r_count == ihc_pkg::CK_LO_POS) begin
                    r_rc <= {r_hold, i_hdr.header_byte};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store && r_count == ihc_pkg::TTL_POS) begin
            r_ttl <= i_hdr.header_byte;
        end
        if (i_cmd.store && r_count == ihc_pkg::PROTO_POS) begin
            r_proto <= i_hdr.header_byte;
        end
        if (i_cmd.latch_hc) begin
            r_hc <= n_hc;
        end
    end

    // replay index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx <= '0;
        end else if (i_cmd.latch_hc) begin
            r_rd_idx <= '0;
        end else if (i_cmd.rd_next) begin
            r_rd_idx <= r_rd_idx + 6'd1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_o_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            case (i_cmd.out_src)
                ihc_pkg::SRC_BYTE: begin
                    r_o_byte   <= n_byte;
                    r_o_has    <= 1'b1;
                    r_o_status <= ihc_pkg::ST_FWD;
                    r_o_end    <= rd_last;
                end
                ihc_pkg::SRC_SUM: begin
                    r_o_byte   <= 8'd0;
                    r_o_has    <= 1'b0;
                    r_o_status <= ihc_pkg::ST_BAD_SUM;
                    r_o_end    <= 1'b1;
                end
                default: begin
                    r_o_byte   <= 8'd0;
                    r_o_has    <= 1'b0;
                    r_o_status <= ihc_pkg::ST_BAD_LEN;
                    r_o_end    <= 1'b1;
                end
            endcase
        end
    end

    assign o_res.valid        = r_o_valid;
    assign o_res.out_byte     = r_o_byte;
    assign o_res.has_byte     = r_o_has;
    assign o_res.check_status = r_o_status;
    assign o_res.end_of_run   = r_o_end;

    a_count_in_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r_len)
        else $error("byte count beyond header length");

    a_len_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.start_hdr |=> (r_len >= ihc_pkg::MIN_HDR_BYTES) && (r_len <= MAX_LEN))
        else $error("accepted header length out of range");

endmodule

// ----- sv/ihc_ctrl.sv -----
// controller: collect, check and replay sequencing for the header checker
// depends on ihc_pkg
module ihc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  ihc_pkg::t_dp_sts i_sts,
    output ihc_pkg::t_dp_cmd o_cmd
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_COLLECT = 3'd1;
    localparam logic [2:0] S_CHECK   = 3'd2;
    localparam logic [2:0] S_READ    = 3'd3;
    localparam logic [2:0] S_SEND    = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       in_fire;

    assign o_in_ready = ((r_state == S_IDLE) || (r_state == S_COLLECT)) && i_sts.out_free;
    assign in_fire    = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state) inside
            S_IDLE, S_COLLECT: begin
                if (in_fire) begin
                    if (i_sts.start) begin
                        if (i_sts.len_bad) begin
                            o_cmd.out_load = 1'b1;
                            o_cmd.out_src  = ihc_pkg::SRC_LEN;
                            n_state        = S_IDLE;
                        end else begin
                            o_cmd.start_hdr = 1'b1;
                            n_state         = S_COLLECT;
                        end
                    end else if (r_state == S_COLLECT) begin
                        o_cmd.store = 1'b1;
                        if (i_sts.last_byte) begin
                            n_state = S_CHECK;
                        end
                    end
                end
            end
            S_CHECK: begin
                if (i_sts.sum_ok) begin
                    o_cmd.latch_hc = 1'b1;
                    n_state        = S_READ;
                end else if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_src  = ihc_pkg::SRC_SUM;
                    n_state        = S_IDLE;
                end
            end
            S_READ: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = S_SEND;
            end
            S_SEND: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_src  = ihc_pkg::SRC_BYTE;
                    o_cmd.rd_next  = 1'b1;
                    n_state        = i_sts.rd_last ? S_IDLE : S_READ;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_sts.out_free)
        else $error("output register overwritten");

    a_no_input_in_replay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ || r_state == S_SEND || r_state == S_CHECK) |-> !o_in_ready)
        else $error("input taken during check or replay");

    a_send_follows_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rd_issue |=> r_state == S_SEND)
        else $error("read not followed by send");

endmodule
